// File: src/gws_pkg.sv
// ----------------------------------------------------------------------------
// gws_pkg
// Shared types, codes and sizing helpers for the grid word search block.
// ----------------------------------------------------------------------------
package gws_pkg;

  localparam int MAX_ROWS_DEF     = 256;
  localparam int MAX_COLS_DEF     = 256;
  localparam int MAX_WORD_LEN_DEF = 22;
  localparam int DICT_WORDS_DEF   = 4096;

  typedef enum logic [1:0] {
    MODE_DICT   = 2'd0,
    MODE_GRID   = 2'd1,
    MODE_SEARCH = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    REG_ROWS   = 2'd0,
    REG_COLS   = 2'd1,
    REG_MINLEN = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_WCAP,
    ST_LEN,
    ST_LENW,
    ST_CMP,
    ST_CMPW,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    DIR_N  = 3'd0,
    DIR_NE = 3'd1,
    DIR_E  = 3'd2,
    DIR_SE = 3'd3,
    DIR_S  = 3'd4,
    DIR_SW = 3'd5,
    DIR_W  = 3'd6,
    DIR_NW = 3'd7
  } dir_t;

  typedef struct packed {
    logic       grid_we;
    logic       dict_we;
    logic [7:0] ch;
    logic       eow;
  } load_t;

  // address bits for a store of the given depth
  function automatic int aw(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  // bits to hold a count up to and including n
  function automatic int cw(input int n);
    return $clog2(n + 1);
  endfunction

  function automatic logic signed [1:0] dir_dr(input dir_t d);
    logic signed [1:0] v;
    unique case (d)
      DIR_N, DIR_NE, DIR_NW: v = -2'sd1;
      DIR_E, DIR_W:          v = 2'sd0;
      DIR_SE, DIR_S, DIR_SW: v = 2'sd1;
      default:               v = 2'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [1:0] dir_dc(input dir_t d);
    logic signed [1:0] v;
    unique case (d)
      DIR_NE, DIR_E, DIR_SE: v = 2'sd1;
      DIR_N, DIR_S:          v = 2'sd0;
      DIR_SW, DIR_W, DIR_NW: v = -2'sd1;
      default:               v = 2'sd0;
    endcase
    return v;
  endfunction

endpackage

// File: src/gws_grid_mem.sv
// ----------------------------------------------------------------------------
// gws_grid_mem
// Letter grid store, filled in row-major order, one registered read port.
// ----------------------------------------------------------------------------
module gws_grid_mem #(
  parameter int MAX_ROWS = gws_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = gws_pkg::MAX_COLS_DEF
) (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  gws_pkg::load_t                                      load_i,
  input  logic [gws_pkg::cw(MAX_ROWS*MAX_COLS)-1:0]           limit_i,
  input  logic                                                rd_en_i,
  input  logic [gws_pkg::aw(MAX_ROWS*MAX_COLS)-1:0]           rd_addr_i,
  output logic [7:0]                                          rd_data_o
);
  import gws_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int FW    = cw(DEPTH);
  localparam int AW    = aw(DEPTH);

  logic [7:0]    mem_r [DEPTH];
  logic [7:0]    rdata_r;
  logic [FW-1:0] fill_r;
  logic          wr_en;

  assign wr_en     = load_i.grid_we && (fill_r < limit_i);
  assign rd_data_o = rdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (wr_en) begin
      fill_r <= fill_r + FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[fill_r[AW-1:0]] <= load_i.ch;
    end
    if (rd_en_i) begin
      rdata_r <= mem_r[rd_addr_i];
    end
  end

endmodule

// File: src/gws_dict_mem.sv
// ----------------------------------------------------------------------------
// gws_dict_mem
// Dictionary store: letters in fixed-size word slots plus a length per word.
// ----------------------------------------------------------------------------
module gws_dict_mem #(
  parameter int MAX_WORD_LEN = gws_pkg::MAX_WORD_LEN_DEF,
  parameter int DICT_WORDS   = gws_pkg::DICT_WORDS_DEF
) (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  gws_pkg::load_t                                       load_i,
  output logic [gws_pkg::cw(DICT_WORDS)-1:0]                   count_o,
  input  logic                                                 len_rd_en_i,
  input  logic [gws_pkg::aw(DICT_WORDS)-1:0]                   len_addr_i,
  output logic [gws_pkg::cw(MAX_WORD_LEN)-1:0]                 len_data_o,
  input  logic                                                 let_rd_en_i,
  input  logic [gws_pkg::aw(DICT_WORDS*MAX_WORD_LEN)-1:0]      let_addr_i,
  output logic [7:0]                                           let_data_o
);
  import gws_pkg::*;

  localparam int LDEPTH = DICT_WORDS * MAX_WORD_LEN;
  localparam int CW     = cw(DICT_WORDS);
  localparam int KA     = aw(DICT_WORDS);
  localparam int LW     = cw(MAX_WORD_LEN);
  localparam int BW     = cw(LDEPTH);
  localparam int DA     = aw(LDEPTH);

  logic [7:0]    let_mem_r [LDEPTH];
  logic [LW-1:0] len_mem_r [DICT_WORDS];
  logic [7:0]    let_rdata_r;
  logic [LW-1:0] len_rdata_r;

  logic [CW-1:0] count_r, count_nxt;
  logic [LW-1:0] pend_r, pend_nxt;
  logic          long_r, long_nxt;
  logic [BW-1:0] base_r, base_nxt;
  logic [BW-1:0] let_waddr;
  logic          full, too_long, let_we, len_we;

  assign count_o    = count_r;
  assign len_data_o = len_rdata_r;
  assign let_data_o = let_rdata_r;

  assign full      = (count_r == CW'(DICT_WORDS));
  assign too_long  = long_r || (int'(pend_r) >= MAX_WORD_LEN);
  assign let_waddr = base_r + BW'(pend_r);
  assign let_we    = load_i.dict_we && (int'(pend_r) < MAX_WORD_LEN) && !full;
  assign len_we    = load_i.dict_we && load_i.eow && !too_long && !full;

  always_comb begin
    count_nxt = count_r;
    pend_nxt  = pend_r;
    long_nxt  = long_r;
    base_nxt  = base_r;
    if (load_i.dict_we) begin
      if (int'(pend_r) >= MAX_WORD_LEN) begin
        long_nxt = 1'b1;
      end else begin
        pend_nxt = pend_r + LW'(1);
      end
      if (load_i.eow) begin
        if (len_we) begin
          count_nxt = count_r + CW'(1);
          base_nxt  = base_r + BW'(MAX_WORD_LEN);
        end
        pend_nxt = '0;
        long_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pend_r  <= '0;
      long_r  <= 1'b0;
      base_r  <= '0;
    end else begin
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
      long_r  <= long_nxt;
      base_r  <= base_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (let_we) begin
      let_mem_r[let_waddr[DA-1:0]] <= load_i.ch;
    end
    if (let_rd_en_i) begin
      let_rdata_r <= let_mem_r[let_addr_i];
    end
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem_r[count_r[KA-1:0]] <= pend_r + LW'(1);
    end
    if (len_rd_en_i) begin
      len_rdata_r <= len_mem_r[len_addr_i];
    end
  end

endmodule

// File: src/grid_word_search.sv
// ----------------------------------------------------------------------------
// grid_word_search
// Word search solver: loads a dictionary and a letter grid, then answers
// start-cell/direction queries with one result per word length found.
// ----------------------------------------------------------------------------
// Load words are taken while idle and never raise busy. A search holds busy
// while it walks N cells (N up to MAX_WORD_LEN), then scans the stored
// words one by one through the length and letter memory ports, comparing
// letters only for words that pass the length check and stopping at the
// first mismatch. Results then go out for each length found, from shortest
// to longest (one no-hit result when there is no hit), each registered
// before it reaches the ports. Results appear on out_valid for a single
// cycle each and must be taken as they come.
// ----------------------------------------------------------------------------
module grid_word_search #(
  parameter int MAX_ROWS     = gws_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS     = gws_pkg::MAX_COLS_DEF,
  parameter int MAX_WORD_LEN = gws_pkg::MAX_WORD_LEN_DEF,
  parameter int DICT_WORDS   = gws_pkg::DICT_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_char_code,
  input  logic        in_end_of_word,
  input  logic [7:0]  in_start_row,
  input  logic [7:0]  in_start_col,
  input  logic [2:0]  in_direction,
  output logic        out_valid,
  output logic        out_hit,
  output logic [7:0]  out_hit_row,
  output logic [7:0]  out_hit_col,
  output logic [2:0]  out_hit_dir,
  output logic [4:0]  out_word_length,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gws_pkg::*;

  localparam int GDEPTH = MAX_ROWS * MAX_COLS;
  localparam int GA     = aw(GDEPTH);
  localparam int GF     = cw(GDEPTH);
  localparam int MAXRC  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int RW     = cw((MAXRC > 255) ? MAXRC : 255);
  localparam int NW     = cw(MAX_WORD_LEN);
  localparam int NIW    = aw(MAX_WORD_LEN);
  localparam int CW     = cw(DICT_WORDS);
  localparam int KA     = aw(DICT_WORDS);
  localparam int LDEPTH = DICT_WORDS * MAX_WORD_LEN;
  localparam int BW     = cw(LDEPTH);
  localparam int DA     = aw(LDEPTH);

  // configuration
  logic [8:0] rows_r, cols_r;
  logic [4:0] minlen_r;
  logic       cfg_we;
  reg_idx_t   cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r   <= 9'd256;
      cols_r   <= 9'd256;
      minlen_r <= 5'd3;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ROWS:   rows_r   <= pwdata[8:0];
        REG_COLS:   cols_r   <= pwdata[8:0];
        REG_MINLEN: minlen_r <= pwdata[4:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ROWS:   prdata = {23'd0, rows_r};
      REG_COLS:   prdata = {23'd0, cols_r};
      REG_MINLEN: prdata = {27'd0, minlen_r};
      default:    prdata = '0;
    endcase
  end

  logic [RW-1:0] eff_rows, eff_cols;
  logic [GF-1:0] grid_limit;

  assign eff_rows   = (int'(rows_r) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(rows_r);
  assign eff_cols   = (int'(cols_r) > MAX_COLS) ? RW'(MAX_COLS) : RW'(cols_r);
  assign grid_limit = GF'(int'(eff_rows) * int'(eff_cols));

  // input word decode
  logic  accept;
  mode_t mode;
  load_t load;

  assign accept       = start && !busy;
  assign mode         = mode_t'(in_mode);
  assign load.grid_we = accept && (mode == MODE_GRID);
  assign load.dict_we = accept && (mode == MODE_DICT);
  assign load.ch      = in_char_code;
  assign load.eow     = in_end_of_word;

  // memories
  logic                grid_rd_en, len_rd_en, let_rd_en;
  logic [7:0]          grid_data, let_data;
  logic [NW-1:0]       len_data;
  logic [CW-1:0]       word_count;
  logic [BW-1:0]       let_addr;

  // search state
  state_t              st_r, st_nxt;
  logic [RW-1:0]       row_r, row_nxt, col_r, col_nxt;
  logic [GA-1:0]       lin_r, lin_nxt;
  dir_t                dir_r, dir_nxt;
  logic [7:0]          srow_r, srow_nxt, scol_r, scol_nxt;
  logic [NW-1:0]       n_r, n_nxt, j_r, j_nxt, wlen_r, wlen_nxt, elen_r, elen_nxt;
  logic [CW-1:0]       k_r, k_nxt;
  logic [BW-1:0]       base_r, base_nxt;
  logic [MAX_WORD_LEN-1:0] found_r, found_nxt, len_bit;
  logic [7:0]          word_r [MAX_WORD_LEN];
  logic                word_we;

  logic                ov_r, ov_nxt, ohit_r, ohit_nxt, olast_r, olast_nxt;
  logic [4:0]          olen_r, olen_nxt;

  logic signed [1:0]   dr, dc;
  logic [GA-1:0]       lin_step;
  logic                in_bounds;

  assign dr        = dir_dr(dir_r);
  assign dc        = dir_dc(dir_r);
  assign lin_step  = ((dr < 0) ? -GA'(eff_cols) : (dr > 0) ? GA'(eff_cols) : GA'(0))
                   + GA'(dc);
  assign in_bounds = (row_r < eff_rows) && (col_r < eff_cols);
  assign let_addr  = base_r + BW'(j_r);
  assign len_bit   = MAX_WORD_LEN'(1) << (wlen_r - NW'(1));
  assign busy      = (st_r != ST_IDLE);

  gws_grid_mem #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_grid (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_i    (load),
    .limit_i   (grid_limit),
    .rd_en_i   (grid_rd_en),
    .rd_addr_i (lin_r),
    .rd_data_o (grid_data)
  );

  gws_dict_mem #(
    .MAX_WORD_LEN (MAX_WORD_LEN),
    .DICT_WORDS   (DICT_WORDS)
  ) u_dict (
    .clk         (clk),
    .rst_n       (rst_n),
    .load_i      (load),
    .count_o     (word_count),
    .len_rd_en_i (len_rd_en),
    .len_addr_i  (k_r[KA-1:0]),
    .len_data_o  (len_data),
    .let_rd_en_i (let_rd_en),
    .let_addr_i  (let_addr[DA-1:0]),
    .let_data_o  (let_data)
  );

  always_comb begin
    st_nxt     = st_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    lin_nxt    = lin_r;
    dir_nxt    = dir_r;
    srow_nxt   = srow_r;
    scol_nxt   = scol_r;
    n_nxt      = n_r;
    j_nxt      = j_r;
    wlen_nxt   = wlen_r;
    elen_nxt   = elen_r;
    k_nxt      = k_r;
    base_nxt   = base_r;
    found_nxt  = found_r;
    ov_nxt     = 1'b0;
    ohit_nxt   = ohit_r;
    olast_nxt  = olast_r;
    olen_nxt   = olen_r;
    grid_rd_en = 1'b0;
    len_rd_en  = 1'b0;
    let_rd_en  = 1'b0;
    word_we    = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (accept && (mode == MODE_SEARCH)) begin
          row_nxt  = RW'(in_start_row);
          col_nxt  = RW'(in_start_col);
          lin_nxt  = GA'(int'(in_start_row) * int'(eff_cols) + int'(in_start_col));
          dir_nxt  = dir_t'(in_direction);
          srow_nxt = in_start_row;
          scol_nxt = in_start_col;
          n_nxt    = '0;
          st_nxt   = ST_WALK;
        end
      end
      ST_WALK: begin
        if ((int'(n_r) < MAX_WORD_LEN) && in_bounds) begin
          grid_rd_en = 1'b1;
          st_nxt     = ST_WCAP;
        end else begin
          k_nxt     = '0;
          base_nxt  = '0;
          found_nxt = '0;
          st_nxt    = ST_LEN;
        end
      end
      ST_WCAP: begin
        word_we = 1'b1;
        n_nxt   = n_r + NW'(1);
        row_nxt = row_r + RW'(dr);
        col_nxt = col_r + RW'(dc);
        lin_nxt = lin_r + lin_step;
        st_nxt  = ST_WALK;
      end
      ST_LEN: begin
        if (k_r < word_count) begin
          len_rd_en = 1'b1;
          st_nxt    = ST_LENW;
        end else begin
          elen_nxt = NW'(1);
          st_nxt   = ST_EMIT;
        end
      end
      ST_LENW: begin
        wlen_nxt = len_data;
        if ((int'(len_data) >= int'(minlen_r)) && (len_data <= n_r) &&
            ((found_r & (MAX_WORD_LEN'(1) << (len_data - NW'(1)))) == '0)) begin
          j_nxt  = '0;
          st_nxt = ST_CMP;
        end else begin
          k_nxt    = k_r + CW'(1);
          base_nxt = base_r + BW'(MAX_WORD_LEN);
          st_nxt   = ST_LEN;
        end
      end
      ST_CMP: begin
        let_rd_en = 1'b1;
        st_nxt    = ST_CMPW;
      end
      ST_CMPW: begin
        if ((let_data != word_r[j_r[NIW-1:0]]) || (j_r + NW'(1) == wlen_r)) begin
          if (let_data == word_r[j_r[NIW-1:0]]) begin
            found_nxt = found_r | len_bit;
          end
          k_nxt    = k_r + CW'(1);
          base_nxt = base_r + BW'(MAX_WORD_LEN);
          st_nxt   = ST_LEN;
        end else begin
          j_nxt  = j_r + NW'(1);
          st_nxt = ST_CMP;
        end
      end
      ST_EMIT: begin
        if (found_r == '0) begin
          ov_nxt    = 1'b1;
          ohit_nxt  = 1'b0;
          olen_nxt  = '0;
          olast_nxt = 1'b1;
          st_nxt    = ST_IDLE;
        end else begin
          found_nxt = found_r >> 1;
          elen_nxt  = elen_r + NW'(1);
          if (found_r[0]) begin
            ov_nxt    = 1'b1;
            ohit_nxt  = 1'b1;
            olen_nxt  = 5'(elen_r);
            olast_nxt = ((found_r >> 1) == '0);
            if ((found_r >> 1) == '0) begin
              st_nxt = ST_IDLE;
            end
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r   <= row_nxt;
    col_r   <= col_nxt;
    lin_r   <= lin_nxt;
    dir_r   <= dir_nxt;
    srow_r  <= srow_nxt;
    scol_r  <= scol_nxt;
    n_r     <= n_nxt;
    j_r     <= j_nxt;
    wlen_r  <= wlen_nxt;
    elen_r  <= elen_nxt;
    k_r     <= k_nxt;
    base_r  <= base_nxt;
    found_r <= found_nxt;
    ohit_r  <= ohit_nxt;
    olast_r <= olast_nxt;
    olen_r  <= olen_nxt;
    if (word_we) begin
      word_r[n_r[NIW-1:0]] <= grid_data;
    end
  end

  assign out_valid       = ov_r;
  assign out_hit         = ohit_r;
  assign out_hit_row     = srow_r;
  assign out_hit_col     = scol_r;
  assign out_hit_dir     = dir_r;
  assign out_word_length = olen_r;
  assign out_last        = olast_r;

endmodule
